### sv/jtdm_pkg.sv
// Shared types, constants and arithmetic helpers for the tank-drive joystick mixer.
`timescale 1ns / 1ps

package jtdm_pkg;

   // Field widths
   localparam int SampleWidth   = 10;
   localparam int AxisWidth     = 9;
   localparam int DutyWidth     = 8;
   localparam int CsrIndexWidth = 2;

   // Register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_DEAD_ZONE  = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SNAP_LEVEL = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_MIN_DUTY   = 2'd2;

   // Register reset values
   localparam logic [DutyWidth-1:0] DEAD_ZONE_RESET  = 8'd80;
   localparam logic [DutyWidth-1:0] SNAP_LEVEL_RESET = 8'd230;
   localparam logic [DutyWidth-1:0] MIN_DUTY_RESET   = 8'd35;

   // Classification thresholds
   localparam logic [DutyWidth-1:0] STOP_LEVEL       = 8'd40;
   localparam logic [DutyWidth-1:0] FORWARD_LEVEL    = 8'd10;
   localparam logic [DutyWidth-1:0] BACKWARD_LEVEL   = 8'd20;
   localparam logic [DutyWidth-1:0] SPOT_RIGHT_LEVEL = 8'd40;
   localparam logic [DutyWidth-1:0] SPOT_LEFT_LEVEL  = 8'd20;
   localparam logic [DutyWidth-1:0] FULL_DUTY        = 8'd255;

   typedef logic signed [AxisWidth-1:0] axis_type;

   // One motor command pair
   typedef struct packed {
      logic                 left_forward;
      logic                 right_forward;
      logic [DutyWidth-1:0] left_duty;
      logic [DutyWidth-1:0] right_duty;
   } drive_type;

   // Magnitude of an axis value; the stored range is -255..255
   function automatic logic [DutyWidth-1:0] axis_mag(axis_type v);
      axis_type a;
      a = v[AxisWidth-1] ? -v : v;
      return a[DutyWidth-1:0];
   endfunction

   // Map a sample to trunc((510*v - 260865)/1023). The map is odd around the
   // midpoint, so fold to the upper half: mag = floor(510*w/1023) - 255.
   // Divide by 1023 as q = n>>10 plus one if (n mod 1024) + q reaches 1023.
   function automatic axis_type map_sample(logic [SampleWidth-1:0] sample);
      logic [SampleWidth-1:0] w;
      logic [18:0]            n;
      logic [8:0]             q0;
      logic [10:0]            r;
      logic [8:0]             q;
      logic [8:0]             m;
      w  = sample[SampleWidth-1] ? sample : ~sample;
      n  = {w, 9'd0} - {8'd0, w, 1'b0};
      q0 = n[18:10];
      r  = {1'b0, n[9:0]} + {2'd0, q0};
      q  = q0 + {8'd0, (r >= 11'd1023)};
      m  = q - 9'd255;
      return sample[SampleWidth-1] ? axis_type'({1'b0, m[7:0]})
                                   : -axis_type'({1'b0, m[7:0]});
   endfunction

   // Apply dead zone first, then snap to full scale
   function automatic axis_type condition_axis(axis_type v,
                                               logic [DutyWidth-1:0] dead_zone,
                                               logic [DutyWidth-1:0] snap_level);
      logic [DutyWidth-1:0] m;
      m = axis_mag(v);
      if (m < dead_zone) begin
         m = '0;
      end
      if (m > snap_level) begin
         m = FULL_DUTY;
      end
      return v[AxisWidth-1] ? -axis_type'({1'b0, m}) : axis_type'({1'b0, m});
   endfunction

endpackage

### sv/jtdm_mix.sv
// Drive mixer: classifies a conditioned axis pair and produces directions and duties.
`timescale 1ns / 1ps

module jtdm_mix import jtdm_pkg::*; (
   input  axis_type             turn_axis,
   input  axis_type             throttle_axis,
   input  logic [DutyWidth-1:0] min_duty,
   output drive_type            drive
);

   // Inner-wheel duty |255 - m|, dropped to zero below the minimum
   function automatic logic [DutyWidth-1:0] inner(logic [9:0] m,
                                                  logic [DutyWidth-1:0] md);
      logic [9:0] d;
      d = (m > 10'd255) ? (m - 10'd255) : (10'd255 - m);
      return (d < {2'd0, md}) ? '0 : d[DutyWidth-1:0];
   endfunction

   logic [DutyWidth-1:0] ax;
   logic [DutyWidth-1:0] ay;
   logic                 x_pos;
   logic                 x_neg;
   logic                 y_pos;
   logic                 y_neg;
   logic [9:0]           y_scaled;

   assign ax    = axis_mag(turn_axis);
   assign ay    = axis_mag(throttle_axis);
   assign x_neg = turn_axis[AxisWidth-1];
   assign y_neg = throttle_axis[AxisWidth-1];
   assign x_pos = !x_neg && (ax != '0);
   assign y_pos = !y_neg && (ay != '0);

   // floor(5*ay/4) for the last octet
   assign y_scaled = {2'd0, ay} + {4'd0, ay[DutyWidth-1:2]};

   // Classify; the first matching rule wins
   always_comb begin
      drive = '0;
      priority if (ax < STOP_LEVEL && ay < STOP_LEVEL) begin
         drive = '0;
      end else if (ax < FORWARD_LEVEL && y_neg) begin
         drive = '{1'b1, 1'b1, ay, ay};
      end else if (ax < BACKWARD_LEVEL && y_pos) begin
         drive = '{1'b0, 1'b0, ay, ay};
      end else if (ay < SPOT_RIGHT_LEVEL && x_pos) begin
         drive = '{1'b1, 1'b0, ax, ax};
      end else if (ay < SPOT_LEFT_LEVEL && x_neg) begin
         drive = '{1'b0, 1'b1, ax, ax};
      end else if (x_pos && y_neg && ax >= ay) begin
         drive = '{1'b1, 1'b0, ax, inner({2'd0, ay}, min_duty)};
      end else if (x_pos && y_neg) begin
         drive = '{1'b1, 1'b1, ay, inner({2'd0, ax}, min_duty)};
      end else if (x_neg && y_neg && ay > ax) begin
         drive = '{1'b1, 1'b1, inner({2'd0, ax}, min_duty), ay};
      end else if (x_neg && y_neg) begin
         drive = '{1'b0, 1'b1, inner({2'd0, ay}, min_duty), ax};
      end else if (x_neg && y_pos && ax > ay) begin
         drive = '{1'b0, 1'b1, ax, inner({2'd0, ay}, min_duty)};
      end else if (x_neg && y_pos) begin
         drive = '{1'b0, 1'b0, ay, inner({2'd0, ax}, min_duty)};
      end else if (x_pos && y_pos && ay >= ax) begin
         drive = '{1'b0, 1'b0, inner({2'd0, ax}, min_duty), ay};
      end else begin
         drive = '{1'b1, 1'b0, inner(y_scaled, min_duty), ax};
      end
   end

endmodule

### sv/joystick_tank_drive_mixer_unit.sv
// Joystick tank-drive mixer top level: sample mapping, axis state and result register.
// Each request carries one 10-bit joystick sample; bit 0 selects the turn axis (1) or
// the throttle axis (0). The block takes one request per clock while req_stall is low
// and gives exactly one response per request, moving on when the response side does not
// stall: the first register holds the mapped axis value, the second holds the mixed
// motor command, and the stored axes are updated as a request leaves the first register.
// req_stall rises only while the response register is full and stalled. The csr port is
// always ready; index 0 is dead_zone (reset 80), 1 is snap_level (reset 230), 2 is
// min_duty (reset 35), other indexes are ignored. Write registers only while idle.
`timescale 1ns / 1ps

module joystick_tank_drive_mixer_unit import jtdm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [SampleWidth-1:0]   req_sample,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_left_forward,
   output logic                     rsp_right_forward,
   output logic [DutyWidth-1:0]     rsp_left_duty,
   output logic [DutyWidth-1:0]     rsp_right_duty,
   // configuration channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [DutyWidth-1:0]     csr_data
);

   logic [DutyWidth-1:0] dead_zone_ff;
   logic [DutyWidth-1:0] snap_level_ff;
   logic [DutyWidth-1:0] min_duty_ff;

   logic                 map_valid_ff;
   logic                 map_valid_in;
   logic                 map_turn_ff;
   axis_type             map_axis_ff;

   axis_type             turn_axis_ff;
   axis_type             throttle_axis_ff;
   axis_type             turn_axis_in;
   axis_type             throttle_axis_in;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   drive_type            rsp_drive_ff;
   drive_type            drive;

   logic                 out_free;
   logic                 advance;
   logic                 req_take;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff  <= DEAD_ZONE_RESET;
         snap_level_ff <= SNAP_LEVEL_RESET;
         min_duty_ff   <= MIN_DUTY_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEAD_ZONE:  dead_zone_ff  <= csr_data;
            CSR_SNAP_LEVEL: snap_level_ff <= csr_data;
            CSR_MIN_DUTY:   min_duty_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Flow control: advance when the response register can take a result
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = map_valid_ff && out_free;
   assign req_stall = map_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign map_valid_in = req_take || (map_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   // Map stage: hold the mapped sample and its axis select
   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= 1'b0;
      end else begin
         map_valid_ff <= map_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         map_turn_ff <= req_sample[0];
         map_axis_ff <= map_sample(req_sample);
      end
   end

   // Replace the sampled axis, then condition both with current registers
   assign turn_axis_in     = condition_axis(map_turn_ff ? map_axis_ff : turn_axis_ff,
                                            dead_zone_ff, snap_level_ff);
   assign throttle_axis_in = condition_axis(map_turn_ff ? throttle_axis_ff : map_axis_ff,
                                            dead_zone_ff, snap_level_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         turn_axis_ff     <= '0;
         throttle_axis_ff <= '0;
      end else if (advance) begin
         turn_axis_ff     <= turn_axis_in;
         throttle_axis_ff <= throttle_axis_in;
      end
   end

   jtdm_mix u_mix (
      .turn_axis     (turn_axis_in),
      .throttle_axis (throttle_axis_in),
      .min_duty      (min_duty_ff),
      .drive         (drive)
   );

   // Response register: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_drive_ff <= drive;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_forward  = rsp_drive_ff.left_forward;
   assign rsp_right_forward = rsp_drive_ff.right_forward;
   assign rsp_left_duty     = rsp_drive_ff.left_duty;
   assign rsp_right_duty    = rsp_drive_ff.right_duty;

   // Stored axes never leave -255..255
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      turn_axis_ff != 9'sh100 && throttle_axis_ff != 9'sh100)
      else $error("stored axis out of range");

   // An advancing request always lands in the response register
   a_advance_lands: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced request lost");

   // A blocked request stays in the map stage
   a_map_holds: assert property (@(posedge clock) disable iff (reset)
      (map_valid_ff && !out_free) |=> (map_valid_ff && $stable(map_axis_ff)))
      else $error("blocked request dropped");

   // An empty map stage never stalls the request side
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !map_valid_ff |-> !req_stall)
      else $error("stall while map stage empty");

endmodule

### tb/testbench.sv
// Self-checking testbench for the joystick tank-drive mixer.
`timescale 1ns / 1ps

module testbench import jtdm_pkg::*; ();

   localparam int CycleLimit    = 200000;
   localparam int DirectedCount = 23;
   localparam int LongHold      = 60;

   // Index past the last register; writes to it must be ignored
   localparam logic [CsrIndexWidth-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [SampleWidth-1:0] sample;
      bit                     typed;
      logic                   lf;
      logic                   rf;
      logic [DutyWidth-1:0]   ld;
      logic [DutyWidth-1:0]   rd;
   } directed_row_type;

   // Walk the stick through every class; typed rows hold values read off by hand
   directed_row_type directed_rows [DirectedCount] = '{
      '{10'd0,    1'b1, 1'b1, 1'b1, 8'd255, 8'd255}, // full forward from reset
      '{10'd1023, 1'b1, 1'b1, 1'b0, 8'd255, 8'd0},   // full right turn, inner cut
      '{10'd1022, 1'b1, 1'b0, 1'b0, 8'd0,   8'd255}, // throttle snaps to full back
      '{10'd1,    1'b1, 1'b0, 1'b0, 8'd255, 8'd0},   // full left turn, backward
      '{10'd512,  1'b1, 1'b0, 1'b1, 8'd255, 8'd255}, // spot turn left at full
      '{10'd511,  1'b1, 1'b0, 1'b0, 8'd0,   8'd0},   // both centered: stop
      '{10'd900,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // straight backward
      '{10'd512,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // back to stop
      '{10'd851,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // spot turn right
      '{10'd171,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // spot turn left, negative truncation
      '{10'd671,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // just inside the dead zone
      '{10'd672,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // just outside the dead zone
      '{10'd974,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // at the snap level
      '{10'd975,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // over snap: octet eight, inner cut
      '{10'd812,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // octet eight with scaled inner
      '{10'd0,    1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // forward right, tie on magnitude goes to turn
      '{10'd913,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // forward right, inner from turn
      '{10'd111,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // forward left, throttle dominant
      '{10'd210,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // forward left, turn dominant
      '{10'd812,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // backward left, turn dominant
      '{10'd1022, 1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // backward left, throttle dominant
      '{10'd913,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0},   // backward right, throttle dominant
      '{10'd210,  1'b0, 1'b0, 1'b0, 8'd0,   8'd0}    // forward right, turn dominant
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [SampleWidth-1:0]   req_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic                     rsp_left_forward;
   logic                     rsp_right_forward;
   logic [DutyWidth-1:0]     rsp_left_duty;
   logic [DutyWidth-1:0]     rsp_right_duty;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [DutyWidth-1:0]     csr_data = '0;

   // Mixer state mirrored by the predictor
   logic [DutyWidth-1:0] dead_zone_level  = DEAD_ZONE_RESET;
   logic [DutyWidth-1:0] snap_level_value = SNAP_LEVEL_RESET;
   logic [DutyWidth-1:0] min_duty_level   = MIN_DUTY_RESET;
   int                   turn_level       = 0;
   int                   throttle_level   = 0;

   drive_type expected_drives [$];
   drive_type predicted_drive;
   drive_type typed_drive;
   bit        row_typed = 1'b0;
   int        mismatch_count = 0;
   int        cycle_count = 0;

   bit sender_idles      = 1'b1;
   bit receiver_idles    = 1'b1;
   bit long_hold_request = 1'b0;
   int hold_left         = 0;
   int stall_left        = 0;

   joystick_tank_drive_mixer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_left_forward  (rsp_left_forward),
      .rsp_right_forward (rsp_right_forward),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Dead zone first, then snap to full scale
   function automatic int shape_axis(int v);
      int m;
      int dz;
      int sl;
      m  = (v < 0) ? -v : v;
      dz = dead_zone_level;
      sl = snap_level_value;
      if (m < dz) v = 0;
      if (v > sl) v = 255;
      else if (v < -sl) v = -255;
      return v;
   endfunction

   // Inner wheel runs at the distance from full scale, cut below min duty
   function automatic int inner_wheel_duty(int m);
      int d;
      int md;
      d  = 255 - m;
      md = min_duty_level;
      if (d < 0) d = -d;
      if (d < md) d = 0;
      return d;
   endfunction

   // Map one sample, refresh both axes and classify the stick position
   function automatic drive_type mix_sample(logic [SampleWidth-1:0] s);
      int        v;
      int        x;
      int        y;
      int        ax;
      int        ay;
      int        ld;
      int        rd;
      logic      lf;
      logic      rf;
      drive_type r;
      v = s;
      if (s[0]) turn_level = (510 * v - 260865) / 1023;
      else throttle_level = (510 * v - 260865) / 1023;
      turn_level     = shape_axis(turn_level);
      throttle_level = shape_axis(throttle_level);
      x  = turn_level;
      y  = throttle_level;
      ax = (x < 0) ? -x : x;
      ay = (y < 0) ? -y : y;
      if (ax < 40 && ay < 40) begin
         lf = 1'b0; rf = 1'b0; ld = 0; rd = 0;
      end else if (ax < 10 && y < 0) begin
         lf = 1'b1; rf = 1'b1; ld = ay; rd = ay;
      end else if (ax < 20 && y > 0) begin
         lf = 1'b0; rf = 1'b0; ld = ay; rd = ay;
      end else if (ay < 40 && x > 0) begin
         lf = 1'b1; rf = 1'b0; ld = ax; rd = ax;
      end else if (ay < 20 && x < 0) begin
         lf = 1'b0; rf = 1'b1; ld = ax; rd = ax;
      end else if (x > 0 && y < 0 && ax >= ay) begin
         lf = 1'b1; rf = 1'b0; ld = ax; rd = inner_wheel_duty(ay);
      end else if (x > 0 && y < 0) begin
         lf = 1'b1; rf = 1'b1; ld = ay; rd = inner_wheel_duty(ax);
      end else if (x < 0 && y < 0 && ay > ax) begin
         lf = 1'b1; rf = 1'b1; ld = inner_wheel_duty(ax); rd = ay;
      end else if (x < 0 && y < 0) begin
         lf = 1'b0; rf = 1'b1; ld = inner_wheel_duty(ay); rd = ax;
      end else if (x < 0 && y > 0 && ax > ay) begin
         lf = 1'b0; rf = 1'b1; ld = ax; rd = inner_wheel_duty(ay);
      end else if (x < 0 && y > 0) begin
         lf = 1'b0; rf = 1'b0; ld = ay; rd = inner_wheel_duty(ax);
      end else if (x > 0 && y > 0 && ay >= ax) begin
         lf = 1'b0; rf = 1'b0; ld = inner_wheel_duty(ax); rd = ay;
      end else begin
         // shallow right turn while backing: throttle scaled by 5/4
         lf = 1'b1; rf = 1'b0; ld = inner_wheel_duty((5 * ay) / 4); rd = ax;
      end
      r.left_forward  = lf;
      r.right_forward = rf;
      r.left_duty     = ld[7:0];
      r.right_duty    = rd[7:0];
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // Spread samples over the full range, the center band and both ends
   function automatic logic [SampleWidth-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return SampleWidth'($urandom_range(0, 1023));
         6, 7:             return SampleWidth'($urandom_range(312, 711));
         8:                return SampleWidth'($urandom_range(0, 40));
         default:          return SampleWidth'($urandom_range(983, 1023));
      endcase
   endfunction

   // Track register writes, predict each request, check each response
   always @(posedge clock) begin
      if (reset) begin
         dead_zone_level  = DEAD_ZONE_RESET;
         snap_level_value = SNAP_LEVEL_RESET;
         min_duty_level   = MIN_DUTY_RESET;
         turn_level       = 0;
         throttle_level   = 0;
         expected_drives.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_DEAD_ZONE:  dead_zone_level  = csr_data;
               CSR_SNAP_LEVEL: snap_level_value = csr_data;
               CSR_MIN_DUTY:   min_duty_level   = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted_drive = mix_sample(req_sample);
            expected_drives.push_back(row_typed ? typed_drive : predicted_drive);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_drives.size() == 0) begin
               mismatch_count++;
               $error("response with no request outstanding");
            end else begin
               predicted_drive = expected_drives.pop_front();
               check_field("left_forward", predicted_drive.left_forward, rsp_left_forward);
               check_field("right_forward", predicted_drive.right_forward,
                           rsp_right_forward);
               check_field("left_duty", predicted_drive.left_duty, rsp_left_duty);
               check_field("right_duty", predicted_drive.right_duty, rsp_right_duty);
            end
         end
      end
   end

   // Stall the response side in random bursts, or hold off for a long stretch
   always @(negedge clock) begin
      if (long_hold_request) begin
         hold_left         = LongHold;
         long_hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 17);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one request, with an optional idle burst ahead of it
   task automatic send_request(input logic [SampleWidth-1:0] s, input bit typed,
                               input drive_type want);
      int gap;
      gap = 0;
      if (sender_idles && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 18);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_sample  <= s;
      row_typed   = typed;
      typed_drive = want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Drop valid and wait until every response is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_drives.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [DutyWidth-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) send_request(pick_sample(), 1'b0, '0);
   endtask

   initial begin
      drive_type row_want;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed sweep with reset register values
      for (int i = 0; i < DirectedCount; i++) begin
         row_want.left_forward  = directed_rows[i].lf;
         row_want.right_forward = directed_rows[i].rf;
         row_want.left_duty     = directed_rows[i].ld;
         row_want.right_duty    = directed_rows[i].rd;
         send_request(directed_rows[i].sample, directed_rows[i].typed, row_want);
      end
      send_random(100);

      // Hold the response side while requests keep coming, so the block backs up
      long_hold_request = 1'b1;
      sender_idles      = 1'b0;
      send_random(20);
      sender_idles = 1'b1;
      send_random(50);
      wait_drained();
      send_random(50);
      wait_drained();

      // No dead zone, no snap, no duty cut
      write_register(CSR_DEAD_ZONE, 8'd0);
      write_register(CSR_SNAP_LEVEL, 8'd255);
      write_register(CSR_MIN_DUTY, 8'd0);
      send_random(200);
      wait_drained();

      // Widest dead zone, snap everything, cut every inner duty
      write_register(CSR_DEAD_ZONE, 8'd255);
      write_register(CSR_SNAP_LEVEL, 8'd0);
      write_register(CSR_MIN_DUTY, 8'd255);
      send_random(100);
      wait_drained();

      // Random settings; the unused index must leave them alone
      for (int k = 0; k < 2; k++) begin
         write_register(CSR_DEAD_ZONE, DutyWidth'($urandom_range(0, 255)));
         write_register(CSR_SNAP_LEVEL, DutyWidth'($urandom_range(0, 255)));
         write_register(CSR_MIN_DUTY, DutyWidth'($urandom_range(0, 255)));
         write_register(CSR_UNUSED, DutyWidth'($urandom_range(0, 255)));
         send_random(100);
         wait_drained();
      end

      // Near-default settings, then a final stretch at full rate
      write_register(CSR_DEAD_ZONE, DutyWidth'($urandom_range(0, 60)));
      write_register(CSR_SNAP_LEVEL, DutyWidth'($urandom_range(150, 255)));
      write_register(CSR_MIN_DUTY, DutyWidth'($urandom_range(0, 100)));
      send_random(200);
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      send_random(150);
      wait_drained();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### sim.f
sv/jtdm_pkg.sv
sv/jtdm_mix.sv
sv/joystick_tank_drive_mixer_unit.sv
tb/testbench.sv
